// ===== sv/aes_pkg.sv =====
// ----------------------------------------------------------------------------
// aes_pkg
// Shared types, constants, substitution tables and byte-level helpers for
// the AES-128 block unit.
// ----------------------------------------------------------------------------
`default_nettype none

package aes_pkg;

  localparam logic [3:0] AES_ROUNDS = 4'd10;
  localparam int         CFG_IDX_W  = 2;
  localparam int         CFG_DATA_W = 64;

  localparam logic [CFG_IDX_W-1:0] CFG_KEY_HIGH   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_KEY_LOW    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_CHAIN_MODE = 2'd2;

  localparam logic [7:0] RCON_FIRST = 8'h01;
  localparam logic [7:0] GF_POLY    = 8'h1b;

  typedef enum logic [1:0] {
    ST_KEY,
    ST_IDLE,
    ST_RUN
  } ctrl_state_t;

  typedef struct packed {
    logic       ks_init;
    logic       ks_step;
    logic [3:0] ks_idx;
    logic       load;
    logic       round;
    logic [3:0] rnd;
    logic       out_load;
  } dp_cmd_t;

  localparam logic [7:0] SBOX [256] = '{
    8'h63,8'h7C,8'h77,8'h7B,8'hF2,8'h6B,8'h6F,8'hC5,8'h30,8'h01,8'h67,8'h2B,8'hFE,8'hD7,8'hAB,8'h76,
    8'hCA,8'h82,8'hC9,8'h7D,8'hFA,8'h59,8'h47,8'hF0,8'hAD,8'hD4,8'hA2,8'hAF,8'h9C,8'hA4,8'h72,8'hC0,
    8'hB7,8'hFD,8'h93,8'h26,8'h36,8'h3F,8'hF7,8'hCC,8'h34,8'hA5,8'hE5,8'hF1,8'h71,8'hD8,8'h31,8'h15,
    8'h04,8'hC7,8'h23,8'hC3,8'h18,8'h96,8'h05,8'h9A,8'h07,8'h12,8'h80,8'hE2,8'hEB,8'h27,8'hB2,8'h75,
    8'h09,8'h83,8'h2C,8'h1A,8'h1B,8'h6E,8'h5A,8'hA0,8'h52,8'h3B,8'hD6,8'hB3,8'h29,8'hE3,8'h2F,8'h84,
    8'h53,8'hD1,8'h00,8'hED,8'h20,8'hFC,8'hB1,8'h5B,8'h6A,8'hCB,8'hBE,8'h39,8'h4A,8'h4C,8'h58,8'hCF,
    8'hD0,8'hEF,8'hAA,8'hFB,8'h43,8'h4D,8'h33,8'h85,8'h45,8'hF9,8'h02,8'h7F,8'h50,8'h3C,8'h9F,8'hA8,
    8'h51,8'hA3,8'h40,8'h8F,8'h92,8'h9D,8'h38,8'hF5,8'hBC,8'hB6,8'hDA,8'h21,8'h10,8'hFF,8'hF3,8'hD2,
    8'hCD,8'h0C,8'h13,8'hEC,8'h5F,8'h97,8'h44,8'h17,8'hC4,8'hA7,8'h7E,8'h3D,8'h64,8'h5D,8'h19,8'h73,
    8'h60,8'h81,8'h4F,8'hDC,8'h22,8'h2A,8'h90,8'h88,8'h46,8'hEE,8'hB8,8'h14,8'hDE,8'h5E,8'h0B,8'hDB,
    8'hE0,8'h32,8'h3A,8'h0A,8'h49,8'h06,8'h24,8'h5C,8'hC2,8'hD3,8'hAC,8'h62,8'h91,8'h95,8'hE4,8'h79,
    8'hE7,8'hC8,8'h37,8'h6D,8'h8D,8'hD5,8'h4E,8'hA9,8'h6C,8'h56,8'hF4,8'hEA,8'h65,8'h7A,8'hAE,8'h08,
    8'hBA,8'h78,8'h25,8'h2E,8'h1C,8'hA6,8'hB4,8'hC6,8'hE8,8'hDD,8'h74,8'h1F,8'h4B,8'hBD,8'h8B,8'h8A,
    8'h70,8'h3E,8'hB5,8'h66,8'h48,8'h03,8'hF6,8'h0E,8'h61,8'h35,8'h57,8'hB9,8'h86,8'hC1,8'h1D,8'h9E,
    8'hE1,8'hF8,8'h98,8'h11,8'h69,8'hD9,8'h8E,8'h94,8'h9B,8'h1E,8'h87,8'hE9,8'hCE,8'h55,8'h28,8'hDF,
    8'h8C,8'hA1,8'h89,8'h0D,8'hBF,8'hE6,8'h42,8'h68,8'h41,8'h99,8'h2D,8'h0F,8'hB0,8'h54,8'hBB,8'h16};

  localparam logic [7:0] INV_SBOX [256] = '{
    8'h52,8'h09,8'h6A,8'hD5,8'h30,8'h36,8'hA5,8'h38,8'hBF,8'h40,8'hA3,8'h9E,8'h81,8'hF3,8'hD7,8'hFB,
    8'h7C,8'hE3,8'h39,8'h82,8'h9B,8'h2F,8'hFF,8'h87,8'h34,8'h8E,8'h43,8'h44,8'hC4,8'hDE,8'hE9,8'hCB,
    8'h54,8'h7B,8'h94,8'h32,8'hA6,8'hC2,8'h23,8'h3D,8'hEE,8'h4C,8'h95,8'h0B,8'h42,8'hFA,8'hC3,8'h4E,
    8'h08,8'h2E,8'hA1,8'h66,8'h28,8'hD9,8'h24,8'hB2,8'h76,8'h5B,8'hA2,8'h49,8'h6D,8'h8B,8'hD1,8'h25,
    8'h72,8'hF8,8'hF6,8'h64,8'h86,8'h68,8'h98,8'h16,8'hD4,8'hA4,8'h5C,8'hCC,8'h5D,8'h65,8'hB6,8'h92,
    8'h6C,8'h70,8'h48,8'h50,8'hFD,8'hED,8'hB9,8'hDA,8'h5E,8'h15,8'h46,8'h57,8'hA7,8'h8D,8'h9D,8'h84,
    8'h90,8'hD8,8'hAB,8'h00,8'h8C,8'hBC,8'hD3,8'h0A,8'hF7,8'hE4,8'h58,8'h05,8'hB8,8'hB3,8'h45,8'h06,
    8'hD0,8'h2C,8'h1E,8'h8F,8'hCA,8'h3F,8'h0F,8'h02,8'hC1,8'hAF,8'hBD,8'h03,8'h01,8'h13,8'h8A,8'h6B,
    8'h3A,8'h91,8'h11,8'h41,8'h4F,8'h67,8'hDC,8'hEA,8'h97,8'hF2,8'hCF,8'hCE,8'hF0,8'hB4,8'hE6,8'h73,
    8'h96,8'hAC,8'h74,8'h22,8'hE7,8'hAD,8'h35,8'h85,8'hE2,8'hF9,8'h37,8'hE8,8'h1C,8'h75,8'hDF,8'h6E,
    8'h47,8'hF1,8'h1A,8'h71,8'h1D,8'h29,8'hC5,8'h89,8'h6F,8'hB7,8'h62,8'h0E,8'hAA,8'h18,8'hBE,8'h1B,
    8'hFC,8'h56,8'h3E,8'h4B,8'hC6,8'hD2,8'h79,8'h20,8'h9A,8'hDB,8'hC0,8'hFE,8'h78,8'hCD,8'h5A,8'hF4,
    8'h1F,8'hDD,8'hA8,8'h33,8'h88,8'h07,8'hC7,8'h31,8'hB1,8'h12,8'h10,8'h59,8'h27,8'h80,8'hEC,8'h5F,
    8'h60,8'h51,8'h7F,8'hA9,8'h19,8'hB5,8'h4A,8'h0D,8'h2D,8'hE5,8'h7A,8'h9F,8'h93,8'hC9,8'h9C,8'hEF,
    8'hA0,8'hE0,8'h3B,8'h4D,8'hAE,8'h2A,8'hF5,8'hB0,8'hC8,8'hEB,8'hBB,8'h3C,8'h83,8'h53,8'h99,8'h61,
    8'h17,8'h2B,8'h04,8'h7E,8'hBA,8'h77,8'hD6,8'h26,8'hE1,8'h69,8'h14,8'h63,8'h55,8'h21,8'h0C,8'h7D};

  function automatic logic [7:0] xtime(input logic [7:0] b);
    return {b[6:0], 1'b0} ^ (b[7] ? GF_POLY : 8'h00);
  endfunction

  function automatic logic [31:0] sub_word(input logic [31:0] w);
    return {SBOX[w[31:24]], SBOX[w[23:16]], SBOX[w[15:8]], SBOX[w[7:0]]};
  endfunction

  function automatic logic [31:0] mix_col(input logic [31:0] w);
    logic [7:0] a0, a1, a2, a3;
    a0 = w[31:24];
    a1 = w[23:16];
    a2 = w[15:8];
    a3 = w[7:0];
    return {xtime(a0) ^ xtime(a1) ^ a1 ^ a2 ^ a3,
            a0 ^ xtime(a1) ^ xtime(a2) ^ a2 ^ a3,
            a0 ^ a1 ^ xtime(a2) ^ xtime(a3) ^ a3,
            xtime(a0) ^ a0 ^ a1 ^ a2 ^ xtime(a3)};
  endfunction

  function automatic logic [31:0] inv_mix_col(input logic [31:0] w);
    logic [7:0] a [4];
    logic [7:0] m2 [4];
    logic [7:0] m4 [4];
    logic [7:0] m8 [4];
    logic [7:0] m9 [4];
    logic [7:0] mb [4];
    logic [7:0] md [4];
    logic [7:0] me [4];
    for (int j = 0; j < 4; j++) begin
      a[j]  = w[31-8*j -: 8];
      m2[j] = xtime(a[j]);
      m4[j] = xtime(m2[j]);
      m8[j] = xtime(m4[j]);
      m9[j] = m8[j] ^ a[j];
      mb[j] = m8[j] ^ m2[j] ^ a[j];
      md[j] = m8[j] ^ m4[j] ^ a[j];
      me[j] = m8[j] ^ m4[j] ^ m2[j];
    end
    return {me[0] ^ mb[1] ^ md[2] ^ m9[3],
            m9[0] ^ me[1] ^ mb[2] ^ md[3],
            md[0] ^ m9[1] ^ me[2] ^ mb[3],
            mb[0] ^ md[1] ^ m9[2] ^ me[3]};
  endfunction

endpackage

`default_nettype wire

// ===== sv/aes_ifs.sv =====
// ----------------------------------------------------------------------------
// aes_ifs
// Block input and result channels with valid/ready handshake.
// ----------------------------------------------------------------------------
`default_nettype none

interface aes_in_if;
  logic        valid;
  logic        ready;
  logic        kind;
  logic        first_block;
  logic [63:0] data_high;
  logic [63:0] data_low;

  modport source (output valid, kind, first_block, data_high, data_low, input ready);
  modport sink   (input valid, kind, first_block, data_high, data_low, output ready);
endinterface

interface aes_out_if;
  logic        valid;
  logic        ready;
  logic [63:0] result_high;
  logic [63:0] result_low;

  modport source (output valid, result_high, result_low, input ready);
  modport sink   (input valid, result_high, result_low, output ready);
endinterface

`default_nettype wire

// ===== sv/aes_round.sv =====
// ----------------------------------------------------------------------------
// aes_round
// One cipher or inverse-cipher round on a 128-bit state; the last round skips the column mix.
// ----------------------------------------------------------------------------
`default_nettype none

module aes_round (
  input  wire logic [127:0] state_in,
  input  wire logic [127:0] rkey,
  input  wire logic         dec,
  input  wire logic         last,
  output logic      [127:0] state_out
);

  logic [7:0]   sb [16];
  logic [7:0]   tb [16];
  logic [127:0] t;
  logic [127:0] u;

  always_comb begin
    for (int i = 0; i < 16; i++) begin
      sb[i] = state_in[127-8*i -: 8];
    end
    for (int r = 0; r < 4; r++) begin
      for (int c = 0; c < 4; c++) begin
        if (dec) begin
          tb[r + 4*((c + r) & 3)] = aes_pkg::INV_SBOX[sb[r + 4*c]];
        end else begin
          tb[r + 4*c] = aes_pkg::SBOX[sb[r + 4*((c + r) & 3)]];
        end
      end
    end
    for (int i = 0; i < 16; i++) begin
      t[127-8*i -: 8] = tb[i];
    end
    u = dec ? (t ^ rkey) : t;
    for (int c = 0; c < 4; c++) begin
      if (last) begin
        state_out[127-32*c -: 32] = u[127-32*c -: 32];
      end else if (dec) begin
        state_out[127-32*c -: 32] = aes_pkg::inv_mix_col(u[127-32*c -: 32]);
      end else begin
        state_out[127-32*c -: 32] = aes_pkg::mix_col(u[127-32*c -: 32]);
      end
    end
    if (!dec) begin
      state_out = state_out ^ rkey;
    end
  end

endmodule

`default_nettype wire

// ===== sv/aes_dp.sv =====
// ----------------------------------------------------------------------------
// aes_dp
// Datapath: configuration registers, round key schedule and store, cipher
// state, chaining value and result register.
// ----------------------------------------------------------------------------
`default_nettype none

module aes_dp (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire aes_pkg::dp_cmd_t               cmd,
  input  wire logic                           cfg_we,
  input  wire logic [aes_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [aes_pkg::CFG_DATA_W-1:0] cfg_wdata,
  input  wire logic                           kind,
  input  wire logic                           first_block,
  input  wire logic [63:0]                    data_high,
  input  wire logic [63:0]                    data_low,
  output logic      [63:0]                    result_high,
  output logic      [63:0]                    result_low
);

  logic [63:0]  key_high;
  logic [63:0]  key_low;
  logic         chain_mode;
  logic [127:0] rk [0:10];
  logic [127:0] kwork;
  logic [7:0]   rc;
  logic [127:0] st;
  logic [127:0] blk;
  logic [127:0] cv_use;
  logic [127:0] chain;
  logic         dec_r;
  logic         cbc_r;

  logic [127:0] knext;
  logic [31:0]  w0n, w1n, w2n, w3n;
  logic [127:0] din;
  logic [127:0] cvsel;
  logic [3:0]   kidx;
  logic [127:0] rnd_out;

  always_comb begin
    w0n   = kwork[127:96] ^ aes_pkg::sub_word({kwork[23:0], kwork[31:24]}) ^ {rc, 24'h0};
    w1n   = kwork[95:64] ^ w0n;
    w2n   = kwork[63:32] ^ w1n;
    w3n   = kwork[31:0] ^ w2n;
    knext = {w0n, w1n, w2n, w3n};
    din   = {data_high, data_low};
    cvsel = first_block ? 128'h0 : chain;
    kidx  = dec_r ? (aes_pkg::AES_ROUNDS - cmd.rnd) : cmd.rnd;
  end

  aes_round u_round (
    .state_in  (st),
    .rkey      (rk[kidx]),
    .dec       (dec_r),
    .last      (cmd.rnd == aes_pkg::AES_ROUNDS),
    .state_out (rnd_out)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      key_high   <= '0;
      key_low    <= '0;
      chain_mode <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        aes_pkg::CFG_KEY_HIGH:   key_high   <= cfg_wdata;
        aes_pkg::CFG_KEY_LOW:    key_low    <= cfg_wdata;
        aes_pkg::CFG_CHAIN_MODE: chain_mode <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.ks_init) begin
      kwork <= {key_high, key_low};
      rk[0] <= {key_high, key_low};
      rc    <= aes_pkg::RCON_FIRST;
    end else if (cmd.ks_step) begin
      kwork           <= knext;
      rk[cmd.ks_idx]  <= knext;
      rc              <= aes_pkg::xtime(rc);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      blk    <= din;
      dec_r  <= kind;
      cbc_r  <= chain_mode;
      cv_use <= cvsel;
      st     <= kind ? (din ^ rk[10])
                     : (din ^ (chain_mode ? cvsel : 128'h0) ^ rk[0]);
    end else if (cmd.round) begin
      st <= rnd_out;
    end
    if (cmd.out_load) begin
      {result_high, result_low} <= rnd_out ^ ((dec_r && cbc_r) ? cv_use : 128'h0);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      chain <= '0;
    end else if (cmd.load && first_block) begin
      chain <= '0;
    end else if (cmd.out_load && cbc_r) begin
      chain <= dec_r ? blk : rnd_out;
    end
  end

endmodule

`default_nettype wire

// ===== sv/aes_ctrl.sv =====
// ----------------------------------------------------------------------------
// aes_ctrl
// Controller: key schedule sequencing, round counting, handshakes.
// ----------------------------------------------------------------------------
`default_nettype none

module aes_ctrl (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             key_wr,
  input  wire logic             in_valid,
  output logic                  in_ready,
  input  wire logic             out_ready,
  output logic                  out_valid,
  output aes_pkg::dp_cmd_t      cmd
);

  aes_pkg::ctrl_state_t state, state_next;
  logic [3:0] cnt;
  logic       out_free;
  logic       accept;

  assign out_free = !out_valid || out_ready;

  always_comb begin
    state_next = state;
    case (state)
      aes_pkg::ST_KEY:  if (cnt == aes_pkg::AES_ROUNDS) state_next = aes_pkg::ST_IDLE;
      aes_pkg::ST_IDLE: if (in_valid) state_next = aes_pkg::ST_RUN;
      aes_pkg::ST_RUN:  if (cnt == aes_pkg::AES_ROUNDS && out_free) begin
        state_next = aes_pkg::ST_IDLE;
      end
      default: state_next = aes_pkg::ST_KEY;
    endcase
    if (key_wr) begin
      state_next = aes_pkg::ST_KEY;
    end
  end

  always_comb begin
    in_ready     = (state == aes_pkg::ST_IDLE) && !key_wr;
    accept       = in_ready && in_valid;
    cmd          = '0;
    cmd.ks_init  = (state == aes_pkg::ST_KEY) && (cnt == 4'd0);
    cmd.ks_step  = (state == aes_pkg::ST_KEY) && (cnt != 4'd0);
    cmd.ks_idx   = cnt;
    cmd.load     = accept;
    cmd.rnd      = cnt;
    cmd.round    = (state == aes_pkg::ST_RUN) &&
                   ((cnt != aes_pkg::AES_ROUNDS) || out_free);
    cmd.out_load = (state == aes_pkg::ST_RUN) &&
                   (cnt == aes_pkg::AES_ROUNDS) && out_free;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= aes_pkg::ST_KEY;
      cnt       <= 4'd0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (key_wr) begin
        cnt <= 4'd0;
      end else begin
        case (state)
          aes_pkg::ST_KEY:  cnt <= (cnt == aes_pkg::AES_ROUNDS) ? 4'd0 : cnt + 4'd1;
          aes_pkg::ST_IDLE: if (accept) cnt <= 4'd1;
          aes_pkg::ST_RUN:  if (cnt != aes_pkg::AES_ROUNDS) cnt <= cnt + 4'd1;
          default:          cnt <= 4'd0;
        endcase
      end
      if (cmd.out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

`default_nettype wire

// ===== sv/aes128_block_cipher_ecb_cbc_unit.sv =====
// ----------------------------------------------------------------------------
// aes128_block_cipher_ecb_cbc_unit
// AES-128 encrypt/decrypt of one block per transaction, ECB or CBC.
// The key add is done at accept; the rounds then run one after another on a single
// round unit. A new block is taken only after the last round has loaded the result.
// A key write re-expands the round keys; no block is taken while that runs.
// Reset clears keys, mode and chaining value and expands the all-zero key.
// ----------------------------------------------------------------------------
`default_nettype none

module aes128_block_cipher_ecb_cbc_unit (
  input  wire logic                           clk,
  input  wire logic                           rst,
  aes_in_if.sink                              in_ch,
  aes_out_if.source                           out_ch,
  input  wire logic                           cfg_we,
  input  wire logic [aes_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [aes_pkg::CFG_DATA_W-1:0] cfg_wdata
);

  aes_pkg::dp_cmd_t cmd;
  logic             key_wr;

  assign key_wr = cfg_we && ((cfg_index == aes_pkg::CFG_KEY_HIGH) ||
                             (cfg_index == aes_pkg::CFG_KEY_LOW));

  aes_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .key_wr    (key_wr),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_ready (out_ch.ready),
    .out_valid (out_ch.valid),
    .cmd       (cmd)
  );

  aes_dp u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_wdata   (cfg_wdata),
    .kind        (in_ch.kind),
    .first_block (in_ch.first_block),
    .data_high   (in_ch.data_high),
    .data_low    (in_ch.data_low),
    .result_high (out_ch.result_high),
    .result_low  (out_ch.result_low)
  );

  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    in_ch.valid && in_ch.ready |=> !in_ch.ready)
    else $error("block accepted while previous block in flight");

  a_key_blocks_input: assert property (@(posedge clk) disable iff (rst)
    key_wr |=> !in_ch.ready)
    else $error("input taken during key expansion");

  a_result_from_run: assert property (@(posedge clk) disable iff (rst)
    $rose(out_ch.valid) |-> $past(!in_ch.ready))
    else $error("result appeared without a block in progress");

endmodule

`default_nettype wire

// ===== tb/sv/aes128_block_cipher_ecb_cbc_unit_tb.sv =====
// ----------------------------------------------------------------------------
// aes128_block_cipher_ecb_cbc_unit_tb
// Self-checking bench for the AES-128 ECB/CBC block unit. Uses directed
// vectors and then random messages, partly with random gaps on both channels.
// Each result is compared with a local cipher model that keeps its own key
// schedule and chaining block.
// ----------------------------------------------------------------------------
`default_nettype none

module aes128_block_cipher_ecb_cbc_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic        kind;
    logic        first_block;
    logic [63:0] data_high;
    logic [63:0] data_low;
  } block_req_t;

  typedef struct packed {
    logic         chk;
    logic [127:0] val;
  } dir_row_t;

  localparam logic KIND_ENC = 1'b0;
  localparam logic KIND_DEC = 1'b1;
  localparam int   SETTLE   = 40;
  localparam int   WD_LIMIT = 20000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [aes_pkg::CFG_IDX_W-1:0] cfg_index = aes_pkg::CFG_KEY_HIGH;
  logic [aes_pkg::CFG_DATA_W-1:0] cfg_wdata = '0;

  aes_in_if  in_ch ();
  aes_out_if out_ch ();

  aes128_block_cipher_ecb_cbc_unit u_top (
    .clk(clk), .rst(rst), .in_ch(in_ch.sink), .out_ch(out_ch.source),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  always #4 clk = ~clk;

  logic [63:0]  key_hi_m, key_lo_m;
  logic         cbc_m;
  logic [31:0]  sched [44];
  logic [127:0] chain_m;
  logic [127:0] expected_blocks [$];
  logic         expected_checked [$];
  logic [127:0] expected_fixed [$];
  int errors = 0, n_blocks = 0, n_results = 0, idle_cycles = 0;
  int in_gap = 0, out_stall = 0;

  function automatic logic [7:0] gm(input logic [7:0] a, input logic [7:0] b);
    logic [7:0] acc;
    acc = '0;
    for (int i = 0; i < 8; i++) begin
      if (b[i]) acc ^= a;
      a = aes_pkg::xtime(a);
    end
    return acc;
  endfunction

  task automatic build_schedule();
    logic [31:0] t;
    logic [7:0] rc;
    rc = 8'h01;
    sched[0] = key_hi_m[63:32]; sched[1] = key_hi_m[31:0];
    sched[2] = key_lo_m[63:32]; sched[3] = key_lo_m[31:0];
    for (int i = 4; i < 44; i++) begin
      t = sched[i-1];
      if (i % 4 == 0) begin
        t = {t[23:0], t[31:24]};
        t = {aes_pkg::SBOX[t[31:24]], aes_pkg::SBOX[t[23:16]],
             aes_pkg::SBOX[t[15:8]], aes_pkg::SBOX[t[7:0]]} ^ {rc, 24'h0};
        rc = aes_pkg::xtime(rc);
      end
      sched[i] = sched[i-4] ^ t;
    end
  endtask

  // state byte i = bits [127-8i -: 8]; column c holds bytes 4c..4c+3
  function automatic logic [127:0] round_xor(input logic [127:0] s, input int r);
    return s ^ {sched[4*r], sched[4*r+1], sched[4*r+2], sched[4*r+3]};
  endfunction

  function automatic logic [127:0] mix_state(input logic [127:0] s, input bit inv);
    logic [7:0] a [4];
    logic [7:0] o;
    logic [127:0] res;
    for (int c = 0; c < 4; c++) begin
      for (int j = 0; j < 4; j++) a[j] = s[127-8*(4*c+j) -: 8];
      for (int r = 0; r < 4; r++) begin
        o = '0;
        for (int j = 0; j < 4; j++)
          o ^= inv ? gm(a[j], (((j-r+4)%4)==0) ? 8'd14 : (((j-r+4)%4)==1) ? 8'd11 :
                               (((j-r+4)%4)==2) ? 8'd13 : 8'd9)
                   : gm(a[j], (((j-r+4)%4)==0) ? 8'd2 : (((j-r+4)%4)==1) ? 8'd3 : 8'd1);
        res[127-8*(4*c+r) -: 8] = o;
      end
    end
    return res;
  endfunction

  function automatic logic [127:0] shift_sub(input logic [127:0] s, input bit inv);
    logic [127:0] t;
    int o;
    for (int r = 0; r < 4; r++)
      for (int c = 0; c < 4; c++) begin
        o = r + 4 * ((c + r) % 4);
        if (inv) t[127-8*o -: 8] = aes_pkg::INV_SBOX[s[127-8*(r+4*c) -: 8]];
        else t[127-8*(r+4*c) -: 8] = aes_pkg::SBOX[s[127-8*o -: 8]];
      end
    return t;
  endfunction

  function automatic logic [127:0] predict_block(input block_req_t q);
    logic [127:0] s, din;
    din = {q.data_high, q.data_low};
    if (q.first_block) chain_m = '0;
    if (q.kind == KIND_ENC) begin
      s = cbc_m ? din ^ chain_m : din;
      s = round_xor(s, 0);
      for (int r = 1; r < 10; r++) s = round_xor(mix_state(shift_sub(s, 0), 0), r);
      s = round_xor(shift_sub(s, 0), 10);
      if (cbc_m) chain_m = s;
    end else begin
      s = round_xor(din, 10);
      for (int r = 9; r >= 1; r--) s = mix_state(round_xor(shift_sub(s, 1), r), 1);
      s = round_xor(shift_sub(s, 1), 0);
      if (cbc_m) begin
        s ^= chain_m;
        chain_m = din;
      end
    end
    return s;
  endfunction

  task automatic write_reg(input logic [aes_pkg::CFG_IDX_W-1:0] idx, input logic [63:0] v);
    @(negedge clk);
    cfg_we <= 1'b1; cfg_index <= idx; cfg_wdata <= v;
    @(negedge clk);
    cfg_we <= 1'b0;
    if (idx == aes_pkg::CFG_KEY_HIGH) begin key_hi_m = v; build_schedule(); end
    else if (idx == aes_pkg::CFG_KEY_LOW) begin key_lo_m = v; build_schedule(); end
    else cbc_m = v[0];
  endtask

  task automatic send_block(input block_req_t q, input bit chk, input logic [127:0] fixed);
    @(negedge clk);
    while (in_gap > 0 && $urandom_range(99) < in_gap) @(negedge clk);
    in_ch.valid <= 1'b1;
    {in_ch.kind, in_ch.first_block, in_ch.data_high, in_ch.data_low} <= q;
    do @(posedge clk); while (!in_ch.ready);
    expected_blocks.push_back(predict_block(q));
    expected_checked.push_back(chk);
    expected_fixed.push_back(fixed);
    n_blocks++;
    @(negedge clk);
    in_ch.valid <= 1'b0;
  endtask

  task automatic drain();
    while (expected_blocks.size() != 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);
  endtask

  always @(negedge clk)
    out_ch.ready <= !(out_stall > 0 && $urandom_range(99) < out_stall);

  always @(posedge clk) begin
    if (!rst && out_ch.valid && out_ch.ready) begin
      n_results++;
      if (expected_blocks.size() == 0) begin
        $display("%0t: unexpected result %h", $time, {out_ch.result_high, out_ch.result_low});
        errors++;
      end else begin
        if (expected_checked[0] && expected_fixed[0] != expected_blocks[0]) begin
          $display("%0t: known answer %h, model %h", $time, expected_fixed[0],
                   expected_blocks[0]);
          errors++;
        end
        if (out_ch.result_high !== expected_blocks[0][127:64]) begin
          $display("%0t: result_high expected %h actual %h", $time,
                   expected_blocks[0][127:64], out_ch.result_high);
          errors++;
        end
        if (out_ch.result_low !== expected_blocks[0][63:0]) begin
          $display("%0t: result_low expected %h actual %h", $time,
                   expected_blocks[0][63:0], out_ch.result_low);
          errors++;
        end
        void'(expected_blocks.pop_front());
        void'(expected_checked.pop_front());
        void'(expected_fixed.pop_front());
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WD_LIMIT) begin
      $display("aes128_block_cipher_ecb_cbc_unit_tb: errors");
      $finish;
    end
  end

  block_req_t dir_reqs [16];
  dir_row_t   dir_exp  [16];

  initial begin
    block_req_t q;
    logic [63:0] k;
    in_ch.valid = 1'b0; in_ch.kind = KIND_ENC; in_ch.first_block = 1'b0;
    in_ch.data_high = '0; in_ch.data_low = '0;
    out_ch.ready = 1'b1;
    key_hi_m = '0; key_lo_m = '0; cbc_m = 1'b0; chain_m = '0;
    build_schedule();

    // zero key/zero block, FIPS-197 C.1 vector, then edges in both modes
    dir_reqs[0]  = '{KIND_ENC, 1'b1, 64'h0, 64'h0};
    dir_exp[0]   = '{1'b1, 128'h66e94bd4ef8a2c3b884cfa59ca342b2e};
    dir_reqs[1]  = '{KIND_DEC, 1'b0, 64'h66e94bd4ef8a2c3b, 64'h884cfa59ca342b2e};
    dir_exp[1]   = '{1'b1, 128'h0};
    dir_reqs[2]  = '{KIND_ENC, 1'b0, 64'h0011223344556677, 64'h8899aabbccddeeff};
    dir_exp[2]   = '{1'b1, 128'h69c4e0d86a7b0430d8cdb78070b4c55a};
    dir_reqs[3]  = '{KIND_DEC, 1'b0, 64'h69c4e0d86a7b0430, 64'hd8cdb78070b4c55a};
    dir_exp[3]   = '{1'b1, 128'h00112233445566778899aabbccddeeff};
    dir_reqs[4]  = '{KIND_ENC, 1'b1, '1, '1};
    dir_reqs[5]  = '{KIND_DEC, 1'b0, '1, '1};
    dir_reqs[6]  = '{KIND_ENC, 1'b0, 64'h8000000000000000, 64'h1};
    dir_reqs[7]  = '{KIND_DEC, 1'b1, 64'h0, 64'h0};
    // CBC section (mode switched before row 8)
    dir_reqs[8]  = '{KIND_ENC, 1'b1, 64'h0011223344556677, 64'h8899aabbccddeeff};
    dir_reqs[9]  = '{KIND_ENC, 1'b0, 64'h0011223344556677, 64'h8899aabbccddeeff};
    dir_reqs[10] = '{KIND_DEC, 1'b0, '1, '1};
    dir_reqs[11] = '{KIND_ENC, 1'b0, 64'h0, 64'h0};
    dir_reqs[12] = '{KIND_DEC, 1'b1, 64'h69c4e0d86a7b0430, 64'hd8cdb78070b4c55a};
    dir_reqs[13] = '{KIND_DEC, 1'b0, 64'h5555aaaa5555aaaa, 64'haaaa5555aaaa5555};
    dir_reqs[14] = '{KIND_ENC, 1'b1, '1, 64'h0};
    dir_reqs[15] = '{KIND_DEC, 1'b0, 64'h0, '1};
    for (int i = 4; i < 16; i++) dir_exp[i] = '{1'b0, 128'h0};

    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    for (int i = 0; i < 16; i++) begin
      if (i == 2) begin
        drain();
        write_reg(aes_pkg::CFG_KEY_HIGH, 64'h0001020304050607);
        write_reg(aes_pkg::CFG_KEY_LOW, 64'h08090a0b0c0d0e0f);
      end
      if (i == 4) begin
        drain();
        write_reg(aes_pkg::CFG_KEY_HIGH, '1);
        write_reg(aes_pkg::CFG_KEY_LOW, '1);
      end
      if (i == 8) begin
        drain();
        write_reg(aes_pkg::CFG_CHAIN_MODE, 64'd1);
      end
      send_block(dir_reqs[i], dir_exp[i].chk, dir_exp[i].val);
    end

    for (int ph = 0; ph < 6; ph++) begin
      drain();
      case (ph % 3)
        0: begin in_gap = 22; out_stall = 88; end
        1: begin in_gap = 88; out_stall = 22; end
        default: begin in_gap = 0; out_stall = 0; end
      endcase
      k = {$urandom, $urandom};
      write_reg(aes_pkg::CFG_KEY_HIGH, (ph == 5) ? 64'h0 : k);
      k = {$urandom, $urandom};
      write_reg(aes_pkg::CFG_KEY_LOW, (ph == 5) ? '1 : k);
      write_reg(aes_pkg::CFG_CHAIN_MODE, {63'd0, ph[0]});
      for (int n = 0; n < 172; n++) begin
        q.kind = 1'($urandom_range(1));
        q.first_block = ($urandom_range(7) == 0);
        q.data_high = {$urandom, $urandom};
        q.data_low = {$urandom, $urandom};
        if ($urandom_range(15) == 0) q.data_high = $urandom_range(1) ? '1 : '0;
        if ($urandom_range(15) == 0) q.data_low = $urandom_range(1) ? '1 : '0;
        // flip the chaining mode once per phase, halfway through its blocks
        if (n == 86) begin
          drain();
          write_reg(aes_pkg::CFG_CHAIN_MODE, {63'd0, !cbc_m});
        end
        send_block(q, 1'b0, '0);
      end
    end

    drain();
    $display("Covered %0d blocks, %0d results: ECB/CBC, both directions, key changes,",
             n_blocks, n_results);
    $display("mode flips mid-message and random channel gaps.");
    if (errors == 0) begin
      $display("aes128_block_cipher_ecb_cbc_unit_tb: clean");
    end else begin
      $display("aes128_block_cipher_ecb_cbc_unit_tb: errors");
    end
    $finish;
  end
endmodule

`default_nettype wire
